@@ sv/apsc_pkg.sv @@
package apsc_pkg;

   // Field widths fixed by the stream format.
   localparam int SAMPLE_WIDTH = 32;
   localparam int BASE_WIDTH   = 16;
   localparam int COUNT_WIDTH  = 16;
   localparam int FIRST_WIDTH  = 16;
   localparam int CH_BITS      = 5;
   localparam int MASK_WIDTH   = 32;
   localparam int MAG_WIDTH    = 31;
   localparam int CC_WIDTH     = 6;

   // Register and saturation constants.
   localparam logic [CC_WIDTH-1:0]    CC_RESET  = 6'd2;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 16'hFFFF;
   localparam logic [MAG_WIDTH-1:0]   MAG_MAX   = 31'h7FFF_FFFF;

   // One accepted input transaction.
   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample;
      logic                    span_start;
      logic [BASE_WIDTH-1:0]   base_frame;
      logic                    clear_summary;
   } req_item_type;

   // The activity summary carried by every result transaction.
   typedef struct packed {
      logic                    has_nonzero;
      logic [COUNT_WIDTH-1:0]  nonzero_frames;
      logic [FIRST_WIDTH-1:0]  first_frame;
      logic [CH_BITS-1:0]      first_channel;
      logic [SAMPLE_WIDTH-1:0] first_value;
      logic [MASK_WIDTH-1:0]   channel_mask;
      logic [MAG_WIDTH-1:0]    peak_magnitude;
   } summary_type;

endpackage

@@ sv/pcm_activity_peak_scanner_core.sv @@
// An accepted request transaction passes the input register, then the response
// register. Throughput: one transaction per cycle unless rsp_tready stalls; each
// register holds one transaction, and the summary update is combinational.
// Reset (synchronous, active high) empties both registers, clears the summary
// and the channel and frame position, and sets the channel count to 2.
module pcm_activity_peak_scanner_core
   import apsc_pkg::*;
#(
   parameter int MAX_CHANNELS = 32,
   parameter int FRAME_BITS   = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [31:0] sample, [47:32] base_frame
   input  logic [47:0]   req_tdata,
   // [0] span_start, [1] clear_summary
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [0] has_nonzero, [16:1] nonzero_frames, [32:17] first_frame,
   // [37:33] first_channel, [69:38] first_value, [101:70] channel_mask,
   // [132:102] peak_magnitude, [135:133] zero
   output logic [135:0]  rsp_tdata,
   input  logic          csr_we,
   input  logic [5:0]    csr_wdata
);

   req_item_type        in_item;
   req_item_type        item;
   logic                item_valid;
   logic                step;
   logic                out_free;
   logic [CC_WIDTH-1:0] cc_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   summary_type         rsp_sum_ff;
   summary_type         cur_sum;
   summary_type         next_sum;

   assign in_item = '{sample:        req_tdata[31:0],
                      span_start:    req_tuser[0],
                      base_frame:    req_tdata[47:32],
                      clear_summary: req_tuser[1]};

   // Channel count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= CC_RESET;
      end else if (csr_we) begin
         cc_ff <= csr_wdata;
      end
   end

   apsc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item_take  (step),
      .item       (item)
   );

   // A registered transaction moves on when the response register frees up.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign step     = item_valid && out_free;

   apsc_summary #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .FRAME_BITS   (FRAME_BITS)
   ) u_summary (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .item          (item),
      .channel_count (cc_ff),
      .cur_sum       (cur_sum),
      .next_sum      (next_sum)
   );

   // Response register.
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_sum_ff <= next_sum;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_sum_ff.peak_magnitude,
                        rsp_sum_ff.channel_mask,
                        rsp_sum_ff.first_value,
                        rsp_sum_ff.first_channel,
                        rsp_sum_ff.first_frame,
                        rsp_sum_ff.nonzero_frames,
                        rsp_sum_ff.has_nonzero};

`ifndef ASSERT_OFF
   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("response pending after reset");

   // A counted frame implies a non-zero sample was seen.
   a_count_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sum_ff.nonzero_frames != '0 |-> rsp_sum_ff.has_nonzero)
      else $error("frame counted without a non-zero sample");

   // Without any non-zero sample the mask and peak stay empty.
   a_empty_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_sum_ff.has_nonzero |->
         rsp_sum_ff.channel_mask == '0 && rsp_sum_ff.peak_magnitude == '0)
      else $error("activity recorded without a non-zero sample");

   // The peak never falls unless the summary is cleared.
   a_peak_grows: assert property (@(posedge clock) disable iff (reset)
      step && !item.clear_summary |=>
         cur_sum.peak_magnitude >= $past(cur_sum.peak_magnitude))
      else $error("peak decreased without a clear");
`endif

endmodule

@@ sv/apsc_in_stage.sv @@
module apsc_in_stage
   import apsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         item_valid,
   input  logic         item_take,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // The register can load whenever it is empty or drains in this cycle.
   assign in_ready = !valid_ff || item_take;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ sv/apsc_summary.sv @@
module apsc_summary
   import apsc_pkg::*;
#(
   parameter int MAX_CHANNELS = 32,
   parameter int FRAME_BITS   = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  req_item_type        item,
   input  logic [CC_WIDTH-1:0] channel_count,
   output summary_type         cur_sum,
   output summary_type         next_sum
);

   logic [CH_BITS-1:0]      chan_pos_ff,   chan_pos_in;
   logic [FRAME_BITS-1:0]   frame_pos_ff,  frame_pos_in;
   logic                    frame_hit_ff,  frame_hit_in;
   logic                    seen_ff,       seen_in;
   logic [COUNT_WIDTH-1:0]  count_ff,      count_in;
   logic [FIRST_WIDTH-1:0]  first_frame_ff, first_frame_in;
   logic [CH_BITS-1:0]      first_ch_ff,   first_ch_in;
   logic [SAMPLE_WIDTH-1:0] first_val_ff,  first_val_in;
   logic [MASK_WIDTH-1:0]   mask_ff,       mask_in;
   logic [MAG_WIDTH-1:0]    peak_ff,       peak_in;

   logic [CC_WIDTH-1:0]             n_eff;
   logic [CH_BITS-1:0]              pos_b;
   logic [FRAME_BITS-1:0]           frame_b;
   logic [FRAME_BITS+BASE_WIDTH-1:0] base_ext;
   logic [FRAME_BITS+FIRST_WIDTH-1:0] frame_ext;
   logic                            hit_b;
   logic                            nonzero;
   logic [SAMPLE_WIDTH-1:0]         neg_val;
   logic [MAG_WIDTH-1:0]            mag;
   logic                            frame_end;

   // Clamp the channel count to the supported range.
   always_comb begin
      if (channel_count == '0) begin
         n_eff = CC_WIDTH'(1);
      end else if (channel_count > CC_WIDTH'(MAX_CHANNELS)) begin
         n_eff = CC_WIDTH'(MAX_CHANNELS);
      end else begin
         n_eff = channel_count;
      end
   end

   // Position after an optional span restart.
   assign base_ext  = {{FRAME_BITS{1'b0}}, item.base_frame};
   assign pos_b     = item.span_start ? '0 : chan_pos_ff;
   assign frame_b   = item.span_start ? base_ext[FRAME_BITS-1:0] : frame_pos_ff;
   assign hit_b     = (item.clear_summary || item.span_start) ? 1'b0 : frame_hit_ff;
   assign frame_ext = {{FIRST_WIDTH{1'b0}}, frame_b};

   // Magnitude of the sample; the most negative value saturates.
   assign nonzero = item.sample != '0;
   assign neg_val = ~item.sample + SAMPLE_WIDTH'(1);
   always_comb begin
      if (item.sample[SAMPLE_WIDTH-1]) begin
         mag = neg_val[SAMPLE_WIDTH-1] ? MAG_MAX : neg_val[MAG_WIDTH-1:0];
      end else begin
         mag = item.sample[MAG_WIDTH-1:0];
      end
   end

   assign frame_end = ({1'b0, pos_b} + CC_WIDTH'(1)) >= n_eff;

   // Summary update for one sample, after an optional clear.
   always_comb begin
      seen_in        = item.clear_summary ? 1'b0 : seen_ff;
      count_in       = item.clear_summary ? '0 : count_ff;
      first_frame_in = item.clear_summary ? '0 : first_frame_ff;
      first_ch_in    = item.clear_summary ? '0 : first_ch_ff;
      first_val_in   = item.clear_summary ? '0 : first_val_ff;
      mask_in        = item.clear_summary ? '0 : mask_ff;
      peak_in        = item.clear_summary ? '0 : peak_ff;
      frame_hit_in   = hit_b;
      if (nonzero) begin
         if (!seen_in) begin
            seen_in        = 1'b1;
            first_frame_in = frame_ext[FIRST_WIDTH-1:0];
            first_ch_in    = pos_b;
            first_val_in   = item.sample;
         end
         mask_in = mask_in | (MASK_WIDTH'(1) << pos_b);
         if (mag > peak_in) begin
            peak_in = mag;
         end
         if (!hit_b) begin
            frame_hit_in = 1'b1;
            if (count_in != COUNT_MAX) begin
               count_in = count_in + COUNT_WIDTH'(1);
            end
         end
      end
      // Advance the channel and frame position.
      if (frame_end) begin
         chan_pos_in  = '0;
         frame_pos_in = frame_b + FRAME_BITS'(1);
         frame_hit_in = 1'b0;
      end else begin
         chan_pos_in  = pos_b + CH_BITS'(1);
         frame_pos_in = frame_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_pos_ff    <= '0;
         frame_pos_ff   <= '0;
         frame_hit_ff   <= 1'b0;
         seen_ff        <= 1'b0;
         count_ff       <= '0;
         first_frame_ff <= '0;
         first_ch_ff    <= '0;
         first_val_ff   <= '0;
         mask_ff        <= '0;
         peak_ff        <= '0;
      end else if (step) begin
         chan_pos_ff    <= chan_pos_in;
         frame_pos_ff   <= frame_pos_in;
         frame_hit_ff   <= frame_hit_in;
         seen_ff        <= seen_in;
         count_ff       <= count_in;
         first_frame_ff <= first_frame_in;
         first_ch_ff    <= first_ch_in;
         first_val_ff   <= first_val_in;
         mask_ff        <= mask_in;
         peak_ff        <= peak_in;
      end
   end

   assign next_sum = '{has_nonzero:    seen_in,
                       nonzero_frames: count_in,
                       first_frame:    first_frame_in,
                       first_channel:  first_ch_in,
                       first_value:    first_val_in,
                       channel_mask:   mask_in,
                       peak_magnitude: peak_in};

   assign cur_sum = '{has_nonzero:    seen_ff,
                      nonzero_frames: count_ff,
                      first_frame:    first_frame_ff,
                      first_channel:  first_ch_ff,
                      first_value:    first_val_ff,
                      channel_mask:   mask_ff,
                      peak_magnitude: peak_ff};

endmodule
